@@ src/rau_pkg.sv @@
// shared types and constants of the rational arithmetic unit
// no dependencies; imported by rau_ctrl, rau_dp and the top level
`default_nettype none
package rau_pkg;

  // command codes
  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_CMP = 3'd4;
  localparam logic [2:0] CMD_INV = 3'd5;
  localparam logic [2:0] CMD_NEG = 3'd6;

  // compare results
  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  // product slots
  localparam logic [1:0] PROD_NUM0 = 2'd0;
  localparam logic [1:0] PROD_NUM1 = 2'd1;
  localparam logic [1:0] PROD_DEN  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       comb;
    logic       gcd_step;
    logic       shift_step;
    logic       div_start;
    logic       div_den;
    logic       div_step;
    logic       out_load;
  } rau_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;
    logic gcd_done;
    logic shift_done;
    logic div_done;
  } rau_stat_t;

endpackage
`default_nettype wire

@@ src/rau_ctrl.sv @@
// controller state machine of the rational arithmetic unit
// depends on rau_pkg; drives rau_dp through rau_cmd_t
`default_nettype none
module rau_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rau_pkg::rau_cmd_t       cmd,
  input  wire rau_pkg::rau_stat_t stat
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_COMB,
    ST_GCD, ST_SHIFT, ST_DIVN, ST_DIVD, ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL0;
        end
      end
      ST_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = PROD_NUM0;
        state_nxt   = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = PROD_NUM1;
        state_nxt   = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = PROD_DEN;
        state_nxt   = ST_COMB;
      end
      ST_COMB: begin
        cmd.comb  = 1'b1;
        state_nxt = stat.skip ? ST_DONE : ST_GCD;
      end
      ST_GCD: begin
        if (stat.gcd_done) state_nxt = ST_SHIFT;
        else cmd.gcd_step = 1'b1;
      end
      ST_SHIFT: begin
        if (stat.shift_done) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIVN;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      ST_DIVN: begin
        if (stat.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_den   = 1'b1;
          state_nxt     = ST_DIVD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_DIVD: begin
        if (stat.div_done) state_nxt = ST_DONE;
        else cmd.div_step = 1'b1;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output valid follows load and transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/rau_dp.sv @@
// datapath: shared multiplier, cross sums, binary gcd, restoring divider
// depends on rau_pkg; sequenced by rau_ctrl
`default_nettype none
module rau_dp #(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire rau_pkg::rau_cmd_t cmd,
  output rau_pkg::rau_stat_t     stat,
  input  wire logic [2:0]        in_command,
  input  wire logic [31:0]       in_a_num,
  input  wire logic [31:0]       in_a_den,
  input  wire logic [31:0]       in_b_num,
  input  wire logic [31:0]       in_b_den,
  output logic [63:0]            out_res_num,
  output logic [62:0]            out_res_den,
  output logic [1:0]             out_order,
  output logic                   out_fault
);
  import rau_pkg::*;

  localparam int OW = OPERAND_WIDTH;
  localparam int PW = 2 * OW;
  localparam int MW = 2 * OW + 1;
  localparam int NW = 2 * OW + 2;
  localparam int CW = $clog2(MW + 1);

  logic [2:0]           op_r;
  logic signed [OW-1:0] an_r, ad_r, bn_r, bd_r;
  logic                 fault_r, skip_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r;
  logic                 sign_r;
  logic [1:0]           order_r;
  logic [MW-1:0]        num_mag_r, den_mag_r;
  logic [MW-1:0]        x_r, y_r;
  logic [CW-1:0]        k_r, cnt_r;
  logic [MW-1:0]        rem_r, quo_r, qn_r;

  // operand capture with fault check
  logic signed [OW-1:0] an_in, ad_in, bn_in, bd_in;
  logic                 fault_in;
  assign an_in = in_a_num[OW-1:0];
  assign ad_in = in_a_den[OW-1:0];
  assign bn_in = in_b_num[OW-1:0];
  assign bd_in = in_b_den[OW-1:0];

  always_comb begin
    fault_in = (ad_in == '0);
    if (in_command <= CMD_CMP && bd_in == '0) fault_in = 1'b1;
    if (in_command == CMD_DIV && bn_in == '0) fault_in = 1'b1;
    if (in_command == CMD_INV && an_in == '0) fault_in = 1'b1;
  end

  // multiplier operand selection
  logic signed [OW-1:0] mx, my;
  logic signed [OW-1:0] one_c;
  assign one_c = OW'(1);

  always_comb begin
    mx = '0;
    my = '0;
    case (cmd.mul_sel)
      PROD_NUM0: begin
        case (op_r)
          CMD_MUL: begin mx = an_r; my = bn_r; end
          CMD_INV: begin mx = ad_r; my = one_c; end
          CMD_NEG: begin mx = '0;   my = '0;   end
          default: begin mx = an_r; my = bd_r; end
        endcase
      end
      PROD_NUM1: begin
        case (op_r)
          CMD_ADD, CMD_SUB, CMD_CMP: begin mx = bn_r; my = ad_r; end
          CMD_NEG: begin mx = an_r; my = one_c; end
          default: begin mx = '0; my = '0; end
        endcase
      end
      default: begin
        case (op_r)
          CMD_DIV: begin mx = ad_r; my = bn_r; end
          CMD_INV: begin mx = an_r; my = one_c; end
          CMD_NEG: begin mx = ad_r; my = one_c; end
          default: begin mx = ad_r; my = bd_r; end
        endcase
      end
    endcase
  end

  logic signed [PW-1:0] prod;
  assign prod = PW'(mx) * PW'(my);

  // cross sum, sign normalization and compare
  logic signed [NW-1:0] num_s, den_s, num_fix, den_fix;
  logic                 den_neg, num_neg;
  logic [1:0]           order_c;

  always_comb begin
    num_s   = (op_r == CMD_ADD) ? NW'(p0_r) + NW'(p1_r) : NW'(p0_r) - NW'(p1_r);
    den_s   = NW'(p2_r);
    den_neg = den_s[NW-1];
    num_fix = den_neg ? -num_s : num_s;
    den_fix = den_neg ? -den_s : den_s;
    num_neg = num_fix[NW-1];
    if (num_fix == '0) order_c = ORD_EQUAL;
    else if (num_neg) order_c = ORD_LESS;
    else order_c = ORD_GREATER;
  end

  // binary gcd step
  logic [MW-1:0] x_nxt, y_nxt;
  logic [CW-1:0] k_nxt;
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    k_nxt = k_r;
    if (!x_r[0] && !y_r[0]) begin
      x_nxt = x_r >> 1;
      y_nxt = y_r >> 1;
      k_nxt = k_r + CW'(1);
    end else if (!x_r[0]) begin
      x_nxt = x_r >> 1;
    end else if (!y_r[0]) begin
      y_nxt = y_r >> 1;
    end else if (x_r >= y_r) begin
      x_nxt = x_r - y_r;
    end else begin
      y_nxt = y_r - x_r;
    end
  end

  // restoring divide step by the gcd
  logic [MW-1:0] gcd_val;
  logic [MW:0]   trial, shifted;
  assign gcd_val = x_r | y_r;
  assign shifted = {rem_r, quo_r[MW-1]};
  assign trial   = shifted - {1'b0, gcd_val};

  assign stat.skip       = skip_r;
  assign stat.gcd_done   = (x_r == '0) || (y_r == '0);
  assign stat.shift_done = (k_r == '0);
  assign stat.div_done   = (cnt_r == '0);

  // signed numerator of the result
  logic signed [NW-1:0] qs;
  assign qs = sign_r ? -$signed({1'b0, qn_r}) : $signed({1'b0, qn_r});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_command;
      an_r    <= an_in;
      ad_r    <= ad_in;
      bn_r    <= bn_in;
      bd_r    <= bd_in;
      fault_r <= fault_in;
      skip_r  <= fault_in || in_command == CMD_CMP || in_command > CMD_NEG;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        PROD_NUM0: p0_r <= prod;
        PROD_NUM1: p1_r <= prod;
        default:   p2_r <= prod;
      endcase
    end
    if (cmd.comb) begin
      order_r   <= (op_r == CMD_CMP && !fault_r) ? order_c : ORD_LESS;
      num_mag_r <= num_neg ? MW'(-num_fix) : MW'(num_fix);
      den_mag_r <= MW'(den_fix);
      x_r       <= num_neg ? MW'(-num_fix) : MW'(num_fix);
      y_r       <= MW'(den_fix);
      k_r       <= '0;
      if (skip_r) begin
        sign_r <= 1'b0;
        qn_r   <= '0;
        quo_r  <= MW'(1);
      end else begin
        sign_r <= num_neg;
      end
    end
    if (cmd.gcd_step) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      k_r <= k_nxt;
    end
    if (cmd.shift_step) begin
      x_r <= x_r << 1;
      y_r <= y_r << 1;
      k_r <= k_r - CW'(1);
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      cnt_r <= CW'(MW);
      if (cmd.div_den) begin
        qn_r  <= quo_r;
        quo_r <= den_mag_r;
      end else begin
        quo_r <= num_mag_r;
      end
    end
    if (cmd.div_step) begin
      cnt_r <= cnt_r - CW'(1);
      if (!trial[MW]) begin
        rem_r <= trial[MW-1:0];
        quo_r <= {quo_r[MW-2:0], 1'b1};
      end else begin
        rem_r <= shifted[MW-1:0];
        quo_r <= {quo_r[MW-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      out_res_num <= 64'(qs);
      out_res_den <= 63'(quo_r);
      out_order   <= order_r;
      out_fault   <= fault_r;
    end
  end

endmodule
`default_nettype wire

@@ src/rational_arithmetic_unit_core.sv @@
// Rational arithmetic unit: add, subtract, multiply, divide, compare, invert
// or negate fractions, giving a result in lowest terms with a positive
// denominator. One item is worked at a time: three products on a shared
// multiplier and one combine step, a binary gcd loop, a left shift by the
// common power of two, and two restoring divisions by the gcd, of the
// numerator and then of the denominator. Compare, faults and unused codes
// skip the gcd, the shift and the divisions. A finished result waits in the
// output register while the next item is accepted.
// depends on rau_pkg, rau_ctrl and rau_dp
`default_nettype none
module rational_arithmetic_unit_core #(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_command,
  input  wire logic [31:0] in_a_num,
  input  wire logic [31:0] in_a_den,
  input  wire logic [31:0] in_b_num,
  input  wire logic [31:0] in_b_den,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_res_num,
  output logic [62:0]      out_res_den,
  output logic [1:0]       out_order,
  output logic             out_fault
);
  import rau_pkg::*;

  rau_cmd_t  cmd;
  rau_stat_t stat;

  // sequencing
  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // arithmetic
  rau_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .stat        (stat),
    .in_command  (in_command),
    .in_a_num    (in_a_num),
    .in_a_den    (in_a_den),
    .in_b_num    (in_b_num),
    .in_b_den    (in_b_den),
    .out_res_num (out_res_num),
    .out_res_den (out_res_den),
    .out_order   (out_order),
    .out_fault   (out_fault)
  );

`ifndef SYNTHESIS
  // a fault always gives zero over one
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> out_res_num == 64'd0 && out_res_den == 63'd1)
    else $error("fault result is not 0/1");

  // reduced denominator never zero
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res_den != 63'd0)
    else $error("zero result denominator");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // compare results carry 0/1
  a_order_frac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_order != ORD_LESS |-> out_res_num == 64'd0 && !out_fault)
    else $error("order set with nonzero fraction or fault");
`endif

endmodule
`default_nettype wire

@@ dv/rational_arithmetic_unit_core_tb.sv @@
// testbench for rational_arithmetic_unit_core: directed and random fraction commands
// checked against an in-bench predictor of the reduced result; depends on rau_pkg
`default_nettype none
module rational_arithmetic_unit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rau_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd7;

  typedef struct {
    logic [63:0] num;
    logic [62:0] den;
    logic [1:0]  ord;
    logic        flt;
  } frac_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_command = '0;
  logic [31:0] in_a_num = '0, in_a_den = '0, in_b_num = '0, in_b_den = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] out_res_num;
  logic [62:0] out_res_den;
  logic [1:0] out_order;
  logic out_fault;

  frac_res_t expected_q[$];
  int errors = 0;
  bit idle_enable = 1'b1;

  rational_arithmetic_unit_core DUT (.*);

  always #10 clk = ~clk;

  initial begin
    #50ms;
    $display("[rational_arithmetic_unit_core] ERROR");
    $finish;
  end

  // euclid on magnitudes
  function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return (x == 0) ? 1 : x;
  endfunction

  function automatic void lowest_terms(input longint n, input longint d,
                                       output longint rn, output longint rd);
    longint unsigned g;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    g = gcd64((n < 0) ? longint'(-n) : n, d);
    rn = n / longint'(g);
    rd = d / longint'(g);
  endfunction

  function automatic frac_res_t predict_fraction(logic [2:0] cmd, logic [31:0] an_i,
      logic [31:0] ad_i, logic [31:0] bn_i, logic [31:0] bd_i);
    frac_res_t r;
    longint an, ad, bn, bd, xn, xd, yn, yd, rn, rd, l, g;
    bit uses_b;
    an = longint'(signed'(an_i));
    ad = longint'(signed'(ad_i));
    bn = longint'(signed'(bn_i));
    bd = longint'(signed'(bd_i));
    uses_b = (cmd <= CMD_CMP);
    rn = 0;
    rd = 1;
    r.ord = ORD_LESS;
    r.flt = 1'b0;
    if (ad == 0 || (uses_b && bd == 0)) begin
      r.flt = 1'b1;
    end else if (cmd != CMD_UNUSED) begin
      lowest_terms(an, ad, xn, xd);
      if (uses_b) lowest_terms(bn, bd, yn, yd);
      else begin
        yn = 0;
        yd = 1;
      end
      case (cmd)
        CMD_ADD: lowest_terms(xn * yd + yn * xd, xd * yd, rn, rd);
        CMD_SUB: lowest_terms(xn * yd - yn * xd, xd * yd, rn, rd);
        CMD_MUL: lowest_terms(xn * yn, xd * yd, rn, rd);
        CMD_DIV: begin
          if (yn == 0) r.flt = 1'b1;
          else lowest_terms(xn * yd, xd * yn, rn, rd);
        end
        CMD_CMP: begin
          l = xn * yd;
          g = yn * xd;
          r.ord = (l < g) ? ORD_LESS : ((l == g) ? ORD_EQUAL : ORD_GREATER);
        end
        CMD_INV: begin
          if (xn == 0) r.flt = 1'b1;
          else lowest_terms(xd, xn, rn, rd);
        end
        default: begin
          rn = -xn;
          rd = xd;
        end
      endcase
    end
    r.num = rn;
    r.den = rd[62:0];
    return r;
  endfunction

  // random gap of roughly 28 in a hundred, valid dropped while idling
  task automatic sender_gap();
    while (idle_enable && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_fraction_op(logic [2:0] cmd, logic [31:0] an, logic [31:0] ad,
                                  logic [31:0] bn, logic [31:0] bd);
    sender_gap();
    expected_q.push_back(predict_fraction(cmd, an, ad, bn, bd));
    in_valid <= 1'b1;
    in_command <= cmd;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // result receiver with random stalls
  always @(posedge clk) begin
    out_ready <= !(idle_enable && $urandom_range(99) < 28);
  end

  // result checker
  always @(posedge clk) begin
    frac_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_res_num !== e.num) begin
          $error("res_num expected %0d actual %0d", $signed(e.num), $signed(out_res_num));
          errors++;
        end
        if (out_res_den !== e.den) begin
          $error("res_den expected %0d actual %0d", e.den, out_res_den);
          errors++;
        end
        if (out_order !== e.ord) begin
          $error("order expected %0d actual %0d", e.ord, out_order);
          errors++;
        end
        if (out_fault !== e.flt) begin
          $error("fault expected %0d actual %0d", e.flt, out_fault);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return 32'($urandom_range(40)) - 32'd20;
      1: return 32'h8000_0000 + 32'($urandom_range(3));
      2: return 32'h7fff_fffc + 32'($urandom_range(3));
      3: return 32'($urandom_range(1000)) * 32'($urandom_range(1000));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_extremes();
    logic [31:0] vals[6];
    vals = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd1, 32'd0, 32'd6};
    foreach (vals[i])
      send_fraction_op(CMD_ADD, vals[i], vals[(i + 1) % 6] | 32'd1, vals[(i + 2) % 6],
                       vals[(i + 3) % 6] | 32'd1);
    send_fraction_op(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
  endtask

  task automatic test_commands();
    for (int c = 0; c < 8; c++) send_fraction_op(3'(c), 32'd6, -32'd4, 32'd10, 32'd15);
  endtask

  task automatic test_faults();
    send_fraction_op(CMD_ADD, 32'd3, 32'd0, 32'd1, 32'd2);
    send_fraction_op(CMD_CMP, 32'd3, 32'd5, 32'd1, 32'd0);
    send_fraction_op(CMD_NEG, 32'd3, 32'd5, 32'd1, 32'd0);
    send_fraction_op(CMD_DIV, 32'd3, 32'd5, 32'd0, -32'd7);
    send_fraction_op(CMD_INV, 32'd0, -32'd9, 32'd1, 32'd1);
    send_fraction_op(CMD_CMP, 32'd2, 32'd4, -32'd3, -32'd6);
    send_fraction_op(CMD_SUB, 32'd5, 32'd7, 32'd10, 32'd14);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      // long stretch with no idling in the middle
      idle_enable = !(i >= count / 3 && i < count / 2);
      send_fraction_op(3'($urandom_range(7)), rand_operand(), rand_operand(),
                       rand_operand(), rand_operand());
      if (i == count / 4) wait_drained();
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_commands();
    test_faults();
    test_random(900);
    wait_drained();
    repeat (500) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("[rational_arithmetic_unit_core] OK");
    end else begin
      $display("[rational_arithmetic_unit_core] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
src/rau_pkg.sv
src/rau_ctrl.sv
src/rau_dp.sv
src/rational_arithmetic_unit_core.sv
dv/rational_arithmetic_unit_core_tb.sv
